// ===== rtl/skl_pkg.sv =====
// Shared types and constants of the snap keyword list parser.
// Holds the word table, the result record and the character codes.
// No dependencies.
`default_nettype none

package skl_pkg;

    localparam int NUM_ROWS  = 11;
    localparam int NUM_WORDS = 23;

    localparam logic [NUM_WORDS-1:0] ALL_ALIVE = '1;
    localparam logic [3:0]           LEN_MAX   = 4'd15;
    localparam logic [3:0]           MIN_LEN   = 4'd3;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    // Word 0 is NONE, then abbreviation and full word for each row.
    // Text is right aligned: character 0 sits at byte WORD_LEN-1.
    localparam logic [127:0] WORD_TEXT [NUM_WORDS] = '{
        "NONE",
        "END", "ENDPOINT",
        "MID", "MIDPOINT",
        "CEN", "CENTER",
        "NOD", "NODE",
        "QUA", "QUADRANT",
        "INT", "INTERSECTION",
        "INS", "INSERT",
        "PER", "PERPENDICULAR",
        "TAN", "TANGENT",
        "NEA", "NEAREST",
        "QUI", "QUICK"
    };

    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
        4'd4,
        4'd3, 4'd8,
        4'd3, 4'd8,
        4'd3, 4'd6,
        4'd3, 4'd4,
        4'd3, 4'd8,
        4'd3, 4'd12,
        4'd3, 4'd6,
        4'd3, 4'd13,
        4'd3, 4'd7,
        4'd3, 4'd7,
        4'd3, 4'd5
    };

    typedef struct packed {
        logic                valid_res;
        logic [NUM_ROWS-1:0] mask;
    } result_t;

    typedef struct packed {
        logic [NUM_WORDS-1:0] row_alive;
        logic [3:0]           token_length;
        logic                 in_token;
        logic [NUM_ROWS-1:0]  acc_mask;
        logic                 any_token;
        logic                 none_hit;
        logic                 failed;
    } parse_state_t;

endpackage

`default_nettype wire

// ===== rtl/skl_match.sv =====
// Character matcher: compares one upcased character against every word
// of the table at a given position. Depends on skl_pkg.
`default_nettype none

module skl_match (
    input  wire logic [7:0]                  character,
    input  wire logic [3:0]                  position,
    output logic [skl_pkg::NUM_WORDS-1:0]    keep
);
    import skl_pkg::*;

    logic [7:0] upper;

    always_comb
    begin
        if (character >= CHAR_LOW_A && character <= CHAR_LOW_Z)
        begin
            upper = character - CASE_DIFF;
        end
        else
        begin
            upper = character;
        end
    end

    for (genvar w = 0; w < NUM_WORDS; w++)
    begin : g_word
        logic [3:0] offset;
        logic [7:0] word_char;

        assign offset    = WORD_LEN[w] - 4'd1 - position;
        assign word_char = WORD_TEXT[w][{offset, 3'b000} +: 8];
        assign keep[w]   = (position < WORD_LEN[w]) && (word_char == upper);
    end

endmodule

`default_nettype wire

// ===== rtl/skl_core.sv =====
// Parser state and token evaluation: one character per step, result on
// the last character. Depends on skl_pkg and skl_match.
`default_nettype none

module skl_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       character,
    input  wire logic             last,
    output skl_pkg::result_t      result
);
    import skl_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t stepped;
    parse_state_t ended;
    parse_state_t reset_state;

    logic                 separator;
    logic [3:0]           base_length;
    logic [NUM_WORDS-1:0] base_alive;
    logic [NUM_WORDS-1:0] keep;
    logic [NUM_ROWS-1:0]  hit;
    logic                 single_hit;
    logic                 ok;

    assign reset_state = '{row_alive: ALL_ALIVE, token_length: 4'd0, in_token: 1'b0,
                           acc_mask: '0, any_token: 1'b0, none_hit: 1'b0,
                           failed: 1'b0};

    assign separator = (character == CHAR_COMMA) || (character == CHAR_SPACE)
                    || (character == CHAR_TAB);

    assign base_length = state_reg.in_token ? state_reg.token_length : 4'd0;
    assign base_alive  = state_reg.in_token ? state_reg.row_alive : ALL_ALIVE;

    skl_match u_match (
        .character (character),
        .position  (base_length),
        .keep      (keep)
    );

    always_comb
    begin
        stepped = state_reg;
        if (!separator)
        begin
            stepped.in_token     = 1'b1;
            stepped.row_alive    = base_alive & keep;
            stepped.token_length = (base_length == LEN_MAX) ? LEN_MAX
                                                            : base_length + 4'd1;
        end
    end

    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        assign hit[r] = |stepped.row_alive[2*r+1 +: 2];
    end

    assign single_hit = (hit != '0) && ((hit & (hit - NUM_ROWS'(1))) == '0);

    always_comb
    begin
        ended = stepped;
        if ((separator || last) && stepped.in_token)
        begin
            ended.in_token = 1'b0;
            if (!stepped.failed)
            begin
                if (stepped.token_length < MIN_LEN)
                begin
                    ended.failed = 1'b1;
                end
                else
                begin
                    ended.any_token = 1'b1;
                    if (stepped.row_alive[0])
                    begin
                        ended.none_hit = 1'b1;
                    end
                    else if (single_hit)
                    begin
                        ended.acc_mask = stepped.acc_mask | hit;
                    end
                    else
                    begin
                        ended.failed = 1'b1;
                    end
                end
            end
        end
    end

    assign ok               = !ended.failed && ended.any_token;
    assign result.valid_res = ok;
    assign result.mask      = (ok && !ended.none_hit) ? ended.acc_mask : '0;

    always_comb
    begin
        state_next = state_reg;
        if (step)
        begin
            state_next = last ? reset_state : ended;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= reset_state;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/snap_keyword_list_parser.sv =====
// Top level of the snap keyword list parser: input register, parser core
// and result register. Depends on skl_pkg and skl_core.
//
// Usage:
//   s_* carries the text, one character per word; s_tlast marks the final
//   character of a text. m_* carries one result word per text.
//   The character is registered on acceptance and processed from the input
//   register; the result of a text is captured in the result register when
//   its last character is processed, and is then shown on m_*.
//   Throughput is one character per cycle, except while a last character
//   waits on the output side; the core updates its token match state per character.
//   Characters that are not last never wait on the output side; a last
//   character waits in the input register only while a previous result
//   is still held unaccepted on m_*, which stalls s_tready in turn.
//   Reset empties both registers and returns the parser to the start of a
//   text; after each result the parser returns to that state by itself.
`default_nettype none

module snap_keyword_list_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] character
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [0] valid_res, [11:1] mask, [15:12] zero
);
    import skl_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_data_reg;
    result_t    result;
    logic       advance;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    skl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .character (in_char_reg),
        .last      (in_last_reg),
        .result    (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg.mask, out_data_reg.valid_res};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for snap_keyword_list_parser: directed texts, then random
// keyword lists, predicted per accepted word and compared on the result stream.
// Depends on skl_pkg (result record) and the block under test.
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef skl_pkg::result_t result_t;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PHASE_CHARS = 500;
    localparam int          WORD_COUNT = 23;
    localparam int          ROW_COUNT = 11;
    localparam int          MIN_TOKEN = 3;
    localparam logic [3:0]  LEN_SAT = 4'd15;
    localparam logic [7:0]  KEY_COMMA = 8'h2C;
    localparam logic [7:0]  KEY_SPACE = 8'h20;
    localparam logic [7:0]  KEY_TAB = 8'h09;
    localparam logic [7:0]  CASE_BIT = 8'h20;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        result_t    exp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] character
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [0] valid_res, [11:1] mask, [15:12] zero

    string spell [WORD_COUNT] = '{
        "NONE",
        "END", "ENDPOINT", "MID", "MIDPOINT", "CEN", "CENTER",
        "NOD", "NODE", "QUA", "QUADRANT", "INT", "INTERSECTION",
        "INS", "INSERT", "PER", "PERPENDICULAR", "TAN", "TANGENT",
        "NEA", "NEAREST", "QUI", "QUICK"
    };

    logic [WORD_COUNT-1:0] p_alive;
    logic [3:0]            p_len;
    logic                  p_in_tok;
    logic [ROW_COUNT-1:0]  p_mask;
    logic                  p_any;
    logic                  p_none;
    logic                  p_bad;

    result_t     pending_results [$];
    stim_row_t   directed_rows [$];
    logic [7:0]  text_buf [$];
    int          mismatches = 0;
    int          src_idle = 0;
    int          snk_idle = 0;
    logic        hold_off = 1'b0;
    int          cycle_count = 0;

    snap_keyword_list_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_parse();
        p_alive  = '1;
        p_len    = '0;
        p_in_tok = 1'b0;
        p_mask   = '0;
        p_any    = 1'b0;
        p_none   = 1'b0;
        p_bad    = 1'b0;
    endfunction

    function automatic void close_token();
        int                   hits;
        logic [ROW_COUNT-1:0] hit;
        hits = 0;
        hit  = '0;
        if (!p_in_tok)
            return;
        p_in_tok = 1'b0;
        if (p_bad)
            return;
        if (int'(p_len) < MIN_TOKEN)
        begin
            p_bad = 1'b1;
            return;
        end
        p_any = 1'b1;
        if (p_alive[0])
        begin
            p_none = 1'b1;
            return;
        end
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            if (p_alive[1 + 2*r +: 2] != 2'b00)
            begin
                hit = '0;
                hit[r] = 1'b1;
                hits++;
            end
        end
        if (hits != 1)
            p_bad = 1'b1;
        else
            p_mask |= hit;
    endfunction

    function automatic bit is_sep(input logic [7:0] c);
        return c == KEY_COMMA || c == KEY_SPACE || c == KEY_TAB;
    endfunction

    // Advance the parse by one character; return 1 when the text ends.
    function automatic bit parse_char(input logic [7:0] c, input logic last,
                                      output result_t res);
        logic [7:0]            up;
        logic [WORD_COUNT-1:0] keep;
        if (is_sep(c))
            close_token();
        else
        begin
            up = (c >= "a" && c <= "z") ? c - CASE_BIT : c;
            if (!p_in_tok)
            begin
                p_in_tok = 1'b1;
                p_alive  = '1;
                p_len    = '0;
            end
            keep = '0;
            for (int w = 0; w < WORD_COUNT; w++)
                if (int'(p_len) < spell[w].len() && spell[w][int'(p_len)] == up)
                    keep[w] = 1'b1;
            p_alive &= keep;
            if (p_len != LEN_SAT)
                p_len++;
        end
        res = '0;
        if (!last)
            return 1'b0;
        close_token();
        res.valid_res = !p_bad && p_any;
        res.mask = (res.valid_res && !p_none) ? p_mask : '0;
        clear_parse();
        return 1'b1;
    endfunction

    task automatic put_word(input logic [7:0] c, input logic last, input logic typed,
                            input result_t exp);
        stim_row_t row;
        row.ch    = c;
        row.last  = last;
        row.typed = typed;
        row.exp   = exp;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic put_text(input string s, input logic typed, input result_t exp);
        for (int i = 0; i < s.len(); i++)
            put_word(s[i], i == s.len() - 1, typed, exp);
    endtask

    // Append n characters of a word in random case, padded with random letters.
    task automatic push_token(input int w, input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = (i < spell[w].len()) ? 8'(spell[w][i]) : 8'($urandom_range(65, 90));
            if ($urandom_range(0, 1) == 1)
                c = c | CASE_BIT;
            text_buf.insert(text_buf.size(), c);
        end
    endtask

    task automatic push_seps(input int n);
        for (int i = 0; i < n; i++)
            case ($urandom_range(0, 2))
                0: text_buf.insert(text_buf.size(), KEY_COMMA);
                1: text_buf.insert(text_buf.size(), KEY_SPACE);
                default: text_buf.insert(text_buf.size(), KEY_TAB);
            endcase
    endtask

    task automatic random_text();
        int ntok;
        int kind;
        int w;
        text_buf.delete();
        if ($urandom_range(0, 49) == 0)
        begin
            push_seps($urandom_range(1, 4));
            return;
        end
        if ($urandom_range(0, 9) == 0)
            push_seps(1);
        ntok = $urandom_range(1, 4);
        for (int t = 0; t < ntok; t++)
        begin
            if (t > 0)
                push_seps($urandom_range(1, 2));
            w = $urandom_range(1, WORD_COUNT - 1);
            if ($urandom_range(0, 29) == 0)
                w = 0;
            kind = $urandom_range(0, 99);
            if (kind < 80)
                push_token(w, $urandom_range(MIN_TOKEN, spell[w].len()));
            else if (kind < 86)
                push_token(w, $urandom_range(1, MIN_TOKEN - 1));
            else if (kind < 92)
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
            else if (kind < 96)
                push_token(w, $urandom_range(14, 20));
            else
                push_token(w, spell[w].len() + 1);
        end
        if ($urandom_range(0, 9) == 0)
            push_seps(1);
    endtask

    // Offer one word at the falling edge; predict at the accepting rising edge.
    task automatic send_char(input logic [7:0] c, input logic last, input logic typed,
                             input result_t given);
        result_t res;
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        if (parse_char(c, last, res))
            pending_results.insert(pending_results.size(), typed ? given : res);
        @(negedge clk);
    endtask

    function automatic void report_mismatch(input string what, input result_t exp,
                                            input logic [15:0] got);
        if (mismatches < 10)
            $display("[%0t] mismatch (%s): expected valid_res=%0b mask=%03h, got %04h",
                     $realtime, what, exp.valid_res, exp.mask, got);
        mismatches++;
    endfunction

    always @(negedge clk)
        m_tready <= !hold_off && ($urandom_range(0, 99) >= snk_idle);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("no result pending", '0, m_tdata);
            else if (m_tdata[0] !== pending_results[0].valid_res)
                report_mismatch("valid_res", pending_results.pop_front(), m_tdata);
            else if (m_tdata[11:1] !== pending_results[0].mask)
                report_mismatch("mask", pending_results.pop_front(), m_tdata);
            else
                void'(pending_results.pop_front());
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** snap_keyword_list_parser: FAILED **");
        $finish;
    end

    initial
    begin
        clear_parse();
        put_text("end", 1'b1, '{valid_res: 1'b1, mask: 11'h001});
        put_text(" \t,", 1'b1, '{valid_res: 1'b0, mask: 11'h000});
        put_text("NoN", 1'b1, '{valid_res: 1'b1, mask: 11'h000});
        put_word(8'hFF, 1'b0, 1'b0, '0);
        put_word(8'h00, 1'b0, 1'b0, '0);
        put_word("q", 1'b1, 1'b1, '{valid_res: 1'b0, mask: 11'h000});
        put_text("a,qu", 1'b1, '{valid_res: 1'b0, mask: 11'h000});
        put_text("quick\tper", 1'b0, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle = 22;
        snk_idle = 56;
        foreach (directed_rows[i])
            send_char(directed_rows[i].ch, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].exp);

        for (int phase = 0; phase < 3; phase++)
        begin
            int sent;
            sent = 0;
            case (phase)
                0: begin src_idle = 22; snk_idle = 56; end
                1: begin src_idle = 56; snk_idle = 22; end
                default: begin src_idle = 0; snk_idle = 0; end
            endcase
            if (phase == 2)
                fork
                    begin
                        int held;
                        hold_off = 1'b1;
                        for (held = 0; held < HOLD_CYCLES; held++)
                            @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            while (sent < PHASE_CHARS)
            begin
                random_text();
                foreach (text_buf[i])
                    send_char(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
                sent += text_buf.size();
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** snap_keyword_list_parser: PASSED **");
        else
            $display("** snap_keyword_list_parser: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
